@@ hw/rtl/mla_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mla_pkg: shared types and constants of the multiplane line averager
// Field widths, register indexes, item kinds and default sizes used by the
// averager and its RAM.
// ---------------------------------------------------------------------------
package mla_pkg;

   // default sizes handed to the top level
   localparam int MAX_PIXELS_DEFAULT = 1024;
   localparam int MAX_PLANES_DEFAULT = 8;
   localparam int CHANNELS_DEFAULT   = 4;
   localparam int TABLE_BITS_DEFAULT = 15;

   // fixed bounds of the row and line-group counters
   localparam int MAX_ROWS = 1024;
   localparam int MAX_AVG  = 16;

   // item field widths
   localparam int CHANNEL_W     = 2;
   localparam int TABLE_INDEX_W = 15;
   localparam int WORD_W        = 16;
   localparam int RANK_W        = 2;
   localparam int PLANE_OUT_W   = 3;
   localparam int PIXEL_X_W     = 10;
   localparam int ROW_OUT_W     = 10;
   localparam int SUM_W         = 20;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 48;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 11;

   typedef enum logic [CSR_AW-1:0] {
      CSR_PIXELS_PER_LINE  = 3'd0,
      CSR_RAW_ROWS         = 3'd1,
      CSR_LINES_TO_AVERAGE = 3'd2,
      CSR_PLANE_COUNT      = 3'd3,
      CSR_SCAN_MODE        = 3'd4,
      CSR_CHANNEL_ENABLE   = 3'd5
   } csr_index_type;

   // item kinds carried on tuser
   localparam logic MODE_TABLE_WRITE = 1'b0;
   localparam logic MODE_SAMPLE      = 1'b1;

   // scan modes
   localparam logic SCAN_TWO_WAY = 1'b0;

   // address width of a store of the given depth, at least one bit
   function automatic int addr_width(input int depth);
      return (depth < 2) ? 1 : $clog2(depth);
   endfunction

endpackage

@@ hw/rtl/mla_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mla_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read each cycle; a read of the address being
// written returns the old word.
// ---------------------------------------------------------------------------
module mla_ram
   import mla_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          we,
   input  logic [addr_width(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]              wdata,
   input  logic                          re,
   input  logic [addr_width(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/multiplane_line_average_lut.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiplane_line_average_lut: line-averaging remapper for multiplane frames
// Maps raw samples through a per-channel lookup table, sums each
// (pixel, plane) over a group of lines and emits the rounded mean on the
// last line of every group.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     tdata: samples, table words; tuser: kind
//  rsp_     out        rsp_tvalid/tready     tdata: averaged result; tlast: frame end
//  csr_     in         csr_we                csr_addr, csr_wdata
//
// One item a cycle unless rsp_ stalls or the sizes settle; a result passes the
// table read and line-sum read-modify-write of stage 1, the reciprocal multiply
// of stage 2 and the output register. A write on the csr port holds req_tready
// low while the clamped sizes, reciprocal and group limit settle; reset does too.
// Both stores come up undefined and need no clearing pass.
// A stalled rsp_ side freezes the whole pipeline; req_tready drops with it.
// ---------------------------------------------------------------------------
module multiplane_line_average_lut
   import mla_pkg::*;
#(
   parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
   parameter int MAX_PLANES = MAX_PLANES_DEFAULT,
   parameter int CHANNELS   = CHANNELS_DEFAULT,
   parameter int TABLE_BITS = TABLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel[1:0], table_index[16:2], table_word[32:17], sample[48:33], zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic                   req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // channel_rank[1:0], plane_out[4:2], pixel_x[14:5], row_out[24:15],
   // average_value[40:25], zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,

   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata
);

   localparam int PX_W    = addr_width(MAX_PIXELS);
   localparam int PPL_W   = $clog2(MAX_PIXELS + 1);
   localparam int PL_W    = addr_width(MAX_PLANES);
   localparam int PLC_W   = $clog2(MAX_PLANES + 1);
   localparam int RW_W    = addr_width(MAX_ROWS);
   localparam int RWC_W   = $clog2(MAX_ROWS + 1);
   localparam int LG_W    = addr_width(MAX_AVG);
   localparam int AVGC_W  = $clog2(MAX_AVG + 1);
   localparam int SA_W    = PX_W + PL_W;
   localparam int SUM_DEPTH = 1 << SA_W;
   localparam int TBL_DEPTH = CHANNELS << TABLE_BITS;
   localparam int TA_W    = addr_width(TBL_DEPTH);
   localparam int NUM_W   = SUM_W + 2;
   localparam int RECIP_K = NUM_W + $clog2(2 * MAX_AVG) + 1;
   localparam int RECIP_W = RECIP_K;
   localparam int SETTLE  = 3;
   localparam int ST_W    = $clog2(SETTLE + 1);

   // -----------------------------------------------------------------------
   // Configuration registers
   // -----------------------------------------------------------------------
   logic [10:0] cfg_ppl_ff;
   logic [10:0] cfg_rows_ff;
   logic [4:0]  cfg_avg_ff;
   logic [3:0]  cfg_planes_ff;
   logic        cfg_scan_ff;
   logic [3:0]  cfg_enable_ff;
   logic [ST_W-1:0] settle_ff;
   logic [ST_W-1:0] settle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ppl_ff    <= 11'd512;
         cfg_rows_ff   <= 11'd512;
         cfg_avg_ff    <= 5'd1;
         cfg_planes_ff <= 4'd1;
         cfg_scan_ff   <= SCAN_TWO_WAY;
         cfg_enable_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_PIXELS_PER_LINE:  cfg_ppl_ff    <= csr_wdata[10:0];
            CSR_RAW_ROWS:         cfg_rows_ff   <= csr_wdata[10:0];
            CSR_LINES_TO_AVERAGE: cfg_avg_ff    <= csr_wdata[4:0];
            CSR_PLANE_COUNT:      cfg_planes_ff <= csr_wdata[3:0];
            CSR_SCAN_MODE:        cfg_scan_ff   <= csr_wdata[0];
            CSR_CHANNEL_ENABLE:   cfg_enable_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // hold input off while derived sizes settle
   always_comb begin
      settle_in = settle_ff;
      if (reset || csr_we) begin
         settle_in = ST_W'(SETTLE);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      settle_ff <= settle_in;
   end

   // -----------------------------------------------------------------------
   // Derived sizes: clamp, reciprocal of twice the line count, group limit
   // -----------------------------------------------------------------------
   logic [RECIP_W-1:0] recip_tbl [2**AVGC_W];

   for (genvar g = 0; g < 2**AVGC_W; g++) begin : g_recip
      if (g == 0 || g > MAX_AVG) begin : g_unused
         assign recip_tbl[g] = '0;
      end else begin : g_used
         localparam longint unsigned RV =
            ((64'd1 << RECIP_K) + 64'(2 * g) - 64'd1) / 64'(2 * g);
         assign recip_tbl[g] = RECIP_W'(RV);
      end
   end

   logic [PPL_W-1:0]   ppl_c, ppl_ff;
   logic [RWC_W-1:0]   rows_c, rows_ff;
   logic [AVGC_W-1:0]  avg_c, avg_ff;
   logic [PLC_W-1:0]   planes_c, planes_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [RWC_W-1:0]   groups_ff, limit_ff;
   logic [RWC_W+RECIP_W:0]  groups_prod;
   logic [RWC_W+AVGC_W-1:0] limit_prod;

   // saturate each size to its legal range
   always_comb begin
      if (cfg_ppl_ff == '0) begin
         ppl_c = PPL_W'(1);
      end else if (32'(cfg_ppl_ff) > MAX_PIXELS) begin
         ppl_c = PPL_W'(MAX_PIXELS);
      end else begin
         ppl_c = PPL_W'(cfg_ppl_ff);
      end
      if (cfg_rows_ff == '0) begin
         rows_c = RWC_W'(1);
      end else if (32'(cfg_rows_ff) > MAX_ROWS) begin
         rows_c = RWC_W'(MAX_ROWS);
      end else begin
         rows_c = RWC_W'(cfg_rows_ff);
      end
      if (cfg_avg_ff == '0) begin
         avg_c = AVGC_W'(1);
      end else if (32'(cfg_avg_ff) > MAX_AVG) begin
         avg_c = AVGC_W'(MAX_AVG);
      end else begin
         avg_c = AVGC_W'(cfg_avg_ff);
      end
      if (cfg_planes_ff == '0) begin
         planes_c = PLC_W'(1);
      end else if (32'(cfg_planes_ff) > MAX_PLANES) begin
         planes_c = PLC_W'(MAX_PLANES);
      end else begin
         planes_c = PLC_W'(cfg_planes_ff);
      end
   end

   // groups = rows / avg through the reciprocal, limit = groups * avg
   assign groups_prod = (RWC_W+RECIP_W+1)'({rows_ff, 1'b0}) *
                        (RWC_W+RECIP_W+1)'(recip_ff);
   assign limit_prod  = (RWC_W+AVGC_W)'(groups_ff) * (RWC_W+AVGC_W)'(avg_ff);

   always_ff @(posedge clock) begin
      ppl_ff    <= ppl_c;
      rows_ff   <= rows_c;
      avg_ff    <= avg_c;
      planes_ff <= planes_c;
      recip_ff  <= recip_tbl[avg_c];
      groups_ff <= groups_prod[RECIP_K +: RWC_W];
      limit_ff  <= limit_prod[RWC_W-1:0];
   end

   // -----------------------------------------------------------------------
   // Accept stage: unpack, wrap positions, issue memory accesses
   // -----------------------------------------------------------------------
   logic                     req_mode;
   logic [CHANNEL_W-1:0]     req_channel;
   logic [TABLE_INDEX_W-1:0] req_table_index;
   logic [WORD_W-1:0]        req_table_word;
   logic [WORD_W-1:0]        req_sample;

   assign req_mode        = req_tuser;
   assign req_channel     = req_tdata[1:0];
   assign req_table_index = req_tdata[16:2];
   assign req_table_word  = req_tdata[32:17];
   assign req_sample      = req_tdata[48:33];

   logic stall, advance, accept, take_sample, tbl_we, channel_ok;
   logic accum0, first0, emit0, fwd0;
   logic [PX_W-1:0] pos_x_ff, pos_x_in, x0;
   logic [PL_W-1:0] pos_plane_ff, pos_plane_in, plane0;
   logic [LG_W-1:0] pos_lig_ff, pos_lig_in, lig0;
   logic [RW_W-1:0] pos_raw_ff, pos_raw_in, raw0;
   logic [SA_W-1:0] idx0;
   logic [RANK_W-1:0] rank0;
   logic [TA_W-1:0] tbl_waddr, tbl_raddr;

   // stage-1 registers, read back by the forward compare
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_fwd_ff, s1_fwd_in;
   logic               s1_first_ff, s1_emit_ff, s1_neg_ff;
   logic [SA_W-1:0]    s1_idx_ff;
   logic [PX_W-1:0]    s1_x_ff;
   logic [PL_W-1:0]    s1_plane_ff;
   logic [RW_W-1:0]    s1_raw_ff;
   logic [RANK_W-1:0]  s1_rank_ff;
   logic [SUM_W-1:0]   s1_fwd_sum_ff;
   logic [SUM_W-1:0]   new_sum;

   logic rsp_tvalid_ff;

   assign stall      = rsp_tvalid_ff & ~rsp_tready;
   assign advance    = ~stall;
   assign req_tready = advance & (settle_ff == '0);
   assign accept     = req_tvalid & req_tready;
   assign channel_ok = 32'(req_channel) < CHANNELS;
   assign take_sample = accept & (req_mode == MODE_SAMPLE) & channel_ok &
                        cfg_enable_ff[req_channel];
   assign tbl_we      = accept & (req_mode == MODE_TABLE_WRITE) & channel_ok;
   assign tbl_waddr   = TA_W'({req_channel, req_table_index[TABLE_BITS-1:0]});
   assign tbl_raddr   = TA_W'({req_channel, req_sample[TABLE_BITS-1:0]});
   assign rank0       = RANK_W'($countones(cfg_enable_ff & ~(4'hF << req_channel)));

   // restart any position that lies beyond its bound
   always_comb begin
      x0     = (PPL_W'(pos_x_ff) >= ppl_ff) ? '0 : pos_x_ff;
      plane0 = (PLC_W'(pos_plane_ff) >= planes_ff) ? '0 : pos_plane_ff;
      lig0   = (AVGC_W'(pos_lig_ff) >= avg_ff) ? '0 : pos_lig_ff;
      raw0   = pos_raw_ff;
      if (RWC_W'(pos_raw_ff) >= rows_ff) begin
         raw0 = '0;
         lig0 = '0;
      end
   end

   assign accum0 = RWC_W'(raw0) < limit_ff;
   assign first0 = lig0 == '0;
   assign emit0  = AVGC_W'(lig0) == avg_ff - 1'b1;
   assign idx0   = {x0, plane0};
   // the sum being written this cycle is the one this item reads
   assign fwd0   = take_sample & accum0 & ~first0 & s1_valid_ff & (s1_idx_ff == idx0);

   // advance plane, then pixel, then line
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_plane_in = pos_plane_ff;
      pos_lig_in   = pos_lig_ff;
      pos_raw_in   = pos_raw_ff;
      if (take_sample) begin
         pos_x_in   = x0;
         pos_lig_in = lig0;
         pos_raw_in = raw0;
         if (PLC_W'(plane0) == planes_ff - 1'b1) begin
            pos_plane_in = '0;
            if (PPL_W'(x0) == ppl_ff - 1'b1) begin
               pos_x_in   = '0;
               pos_lig_in = (AVGC_W'(lig0) == avg_ff - 1'b1) ? '0 : lig0 + 1'b1;
               if (RWC_W'(raw0) == rows_ff - 1'b1) begin
                  pos_raw_in = '0;
                  pos_lig_in = '0;
               end else begin
                  pos_raw_in = raw0 + 1'b1;
               end
            end else begin
               pos_x_in = x0 + 1'b1;
            end
         end else begin
            pos_plane_in = plane0 + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_plane_ff <= '0;
         pos_lig_ff   <= '0;
         pos_raw_ff   <= '0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_plane_ff <= pos_plane_in;
         pos_lig_ff   <= pos_lig_in;
         pos_raw_ff   <= pos_raw_in;
      end
   end

   // -----------------------------------------------------------------------
   // Stores
   // -----------------------------------------------------------------------
   logic [WORD_W-1:0] tbl_rdata;
   logic [SUM_W-1:0]  sum_rdata;
   logic              sum_we;

   mla_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TBL_DEPTH)
   ) u_map_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (req_table_word),
      .re    (take_sample & accum0),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   mla_ram #(
      .WIDTH (SUM_W),
      .DEPTH (SUM_DEPTH)
   ) u_line_sums (
      .clock (clock),
      .we    (sum_we),
      .waddr (s1_idx_ff),
      .wdata (new_sum),
      .re    (take_sample & accum0 & ~first0),
      .raddr (idx0),
      .rdata (sum_rdata)
   );

   // -----------------------------------------------------------------------
   // Stage 1: map, accumulate, write back, find the output row
   // -----------------------------------------------------------------------
   logic [WORD_W-1:0]      mapped;
   logic [SUM_W-1:0]       old_sum;
   logic [NUM_W-1:0]       num1;
   logic [RW_W+RECIP_W:0]  row_prod;
   logic [RW_W-1:0]        row1;

   assign s1_valid_in = take_sample & accum0;
   assign s1_fwd_in   = fwd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s1_fwd_ff   <= s1_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff   <= first0;
         s1_emit_ff    <= emit0;
         s1_neg_ff     <= req_sample[WORD_W-1];
         s1_idx_ff     <= idx0;
         s1_x_ff       <= x0;
         s1_plane_ff   <= plane0;
         s1_raw_ff     <= raw0;
         s1_rank_ff    <= rank0;
         s1_fwd_sum_ff <= new_sum;
      end
   end

   assign mapped  = s1_neg_ff ? '0 : tbl_rdata;
   assign old_sum = s1_fwd_ff ? s1_fwd_sum_ff : sum_rdata;
   assign new_sum = s1_first_ff ? SUM_W'(mapped) : old_sum + SUM_W'(mapped);
   assign sum_we  = s1_valid_ff & advance;
   // rounding numerator 2 * sum + avg
   assign num1    = NUM_W'({new_sum, 1'b0}) + NUM_W'(avg_ff);
   assign row_prod = (RW_W+RECIP_W+1)'({s1_raw_ff, 1'b0}) *
                     (RW_W+RECIP_W+1)'(recip_ff);
   assign row1    = row_prod[RECIP_K +: RW_W];

   // -----------------------------------------------------------------------
   // Stage 2: divide by twice the line count, two-way plane reversal, mark frame end
   // -----------------------------------------------------------------------
   logic               s2_valid_ff, s2_valid_in;
   logic [NUM_W-1:0]   s2_num_ff;
   logic [RW_W-1:0]    s2_row_ff;
   logic [PX_W-1:0]    s2_x_ff;
   logic [PL_W-1:0]    s2_plane_ff;
   logic [RANK_W-1:0]  s2_rank_ff;
   logic [NUM_W+RECIP_W-1:0] mean_prod;
   logic [WORD_W-1:0]  mean2;
   logic [PL_W-1:0]    plane2;
   logic               last2;

   assign s2_valid_in = s1_valid_ff & s1_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_num_ff   <= num1;
         s2_row_ff   <= row1;
         s2_x_ff     <= s1_x_ff;
         s2_plane_ff <= s1_plane_ff;
         s2_rank_ff  <= s1_rank_ff;
      end
   end

   assign mean_prod = (NUM_W+RECIP_W)'(s2_num_ff) * (NUM_W+RECIP_W)'(recip_ff);
   assign mean2     = mean_prod[RECIP_K +: WORD_W];

   always_comb begin
      plane2 = s2_plane_ff;
      if (cfg_scan_ff == SCAN_TWO_WAY && s2_row_ff[0]) begin
         plane2 = PL_W'(planes_ff - 1'b1 - PLC_W'(s2_plane_ff));
      end
   end

   assign last2 = (PPL_W'(s2_x_ff) == ppl_ff - 1'b1) &&
                  (PLC_W'(s2_plane_ff) == planes_ff - 1'b1) &&
                  (RWC_W'(s2_row_ff) == groups_ff - 1'b1);

   // -----------------------------------------------------------------------
   // Output register
   // -----------------------------------------------------------------------
   logic [RANK_W-1:0]      rsp_rank_ff;
   logic [PLANE_OUT_W-1:0] rsp_plane_ff;
   logic [PIXEL_X_W-1:0]   rsp_x_ff;
   logic [ROW_OUT_W-1:0]   rsp_row_ff;
   logic [WORD_W-1:0]      rsp_mean_ff;
   logic                   rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rank_ff  <= s2_rank_ff;
         rsp_plane_ff <= PLANE_OUT_W'(plane2);
         rsp_x_ff     <= PIXEL_X_W'(s2_x_ff);
         rsp_row_ff   <= ROW_OUT_W'(s2_row_ff);
         rsp_mean_ff  <= mean2;
         rsp_last_ff  <= last2;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'b0, rsp_mean_ff, rsp_row_ff, rsp_x_ff, rsp_plane_ff,
                        rsp_rank_ff};

   // -----------------------------------------------------------------------
   // Assertions
   // -----------------------------------------------------------------------
   a_settle_blocks_input: assert property (@(posedge clock)
      settle_ff != '0 |-> !req_tready)
      else $error("item accepted while derived sizes settle");

   a_csr_write_blocks_input: assert property (@(posedge clock)
      csr_we |=> !req_tready)
      else $error("input open right after a register write");

   a_forward_only_on_accumulate: assert property (@(posedge clock)
      s1_fwd_ff |-> s1_valid_ff && !s1_first_ff)
      else $error("line-sum forward on an item that does not read its sum");

   a_stall_freezes_pipeline: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(s2_valid_ff) && $stable(s2_num_ff) && $stable(s1_idx_ff))
      else $error("pipeline moved while the output was stalled");

endmodule

@@ tb/multiplane_line_average_lut_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multiplane_line_average_lut_tb: self-checking bench for the line averager
// Loads the per-channel lookup tables, streams raw multiplane frames under a
// series of size, scan and enable settings, and checks every averaged item
// against a predictor that keeps its own tables, line sums and positions.
// ---------------------------------------------------------------------------
module multiplane_line_average_lut_tb;
   import mla_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int MAX_GAP         = 17;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_ITEMS    = 900;
   localparam int LUT_DEPTH       = CHANNELS_DEFAULT << TABLE_BITS_DEFAULT;
   localparam int SUM_DEPTH       = MAX_PIXELS_DEFAULT * MAX_PLANES_DEFAULT;

   typedef struct packed {
      logic [RANK_W-1:0]      rank;
      logic [PLANE_OUT_W-1:0] plane_out;
      logic [PIXEL_X_W-1:0]   pixel_x;
      logic [ROW_OUT_W-1:0]   row_out;
      logic [WORD_W-1:0]      average_value;
      logic                   frame_last;
   } average_item_t;

   // -------------------------------------------------------------------------
   // Predictor and store of expected averages
   // -------------------------------------------------------------------------
   class line_average_scoreboard;
      logic [WORD_W-1:0]        lut_words [0:LUT_DEPTH-1];
      logic [TABLE_INDEX_W-1:0] lut_keys [CHANNELS_DEFAULT][$];
      logic [SUM_W-1:0]         line_sums [0:SUM_DEPTH-1];
      bit                       sum_written [0:SUM_DEPTH-1];
      int unsigned              pos_x, pos_plane, pos_line, pos_row;
      logic [10:0]              ppl_reg, rows_reg;
      logic [4:0]               avg_reg;
      logic [3:0]               planes_reg, enable_reg;
      logic                     scan_reg;
      average_item_t            expected_averages [$];
      int unsigned              failures, averages_checked, table_writes, samples_used;

      function new();
         ppl_reg    = 11'd512;
         rows_reg   = 11'd512;
         avg_reg    = 5'd1;
         planes_reg = 4'd1;
         scan_reg   = SCAN_TWO_WAY;
         enable_reg = 4'b0001;
      endfunction

      static function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      task report_mismatch(string what);
         failures++;
         if (failures <= 40) $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      function void set_reg(csr_index_type idx, logic [CSR_DW-1:0] value);
         case (idx)
            CSR_PIXELS_PER_LINE:  ppl_reg    = value[10:0];
            CSR_RAW_ROWS:         rows_reg   = value[10:0];
            CSR_LINES_TO_AVERAGE: avg_reg    = value[4:0];
            CSR_PLANE_COUNT:      planes_reg = value[3:0];
            CSR_SCAN_MODE:        scan_reg   = value[0];
            CSR_CHANNEL_ENABLE:   enable_reg = value[3:0];
            default: ;
         endcase
      endfunction

      // pick a sample that is negative or lands on a table word already loaded
      function logic [WORD_W-1:0] pick_sample(logic [1:0] ch);
         if (lut_keys[ch].size() == 0 || $urandom_range(0, 4) == 0)
            return {1'b1, 15'($urandom)};
         return {1'b0, lut_keys[ch][$urandom_range(0, lut_keys[ch].size() - 1)]};
      endfunction

      // true when the next settings cannot make the block read a line sum
      // that was never written
      function bit sums_ready(int unsigned ppl_v, int unsigned rows_v,
                              int unsigned avg_v, int unsigned planes_v);
         int unsigned ppl, rows, avg, planes, x_a, p_a, l_a;
         bit needed;
         ppl    = clamp_size(ppl_v, MAX_PIXELS_DEFAULT);
         rows   = clamp_size(rows_v, MAX_ROWS);
         avg    = clamp_size(avg_v, MAX_AVG);
         planes = clamp_size(planes_v, MAX_PLANES_DEFAULT);
         x_a = (pos_x >= ppl) ? 0 : pos_x;
         p_a = (pos_plane >= planes) ? 0 : pos_plane;
         l_a = (pos_line >= avg || pos_row >= rows) ? 0 : pos_line;
         if (avg == 1) return 1'b1;
         for (int xx = 0; xx < ppl; xx++) begin
            for (int pp = 0; pp < planes; pp++) begin
               needed = (l_a != 0) || (xx < x_a) || (xx == x_a && pp < p_a);
               if (needed && !sum_written[xx * MAX_PLANES_DEFAULT + pp]) return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      // note an accepted input item and work out the average it completes
      function void note_item(logic mode, logic [1:0] ch, logic [TABLE_INDEX_W-1:0] tidx,
                              logic [WORD_W-1:0] tword, logic [WORD_W-1:0] sample);
         int unsigned ppl, rows, avg, planes, groups, idx, mapped, row, plane_o, mean, rank;
         average_item_t item;
         if (mode == MODE_TABLE_WRITE) begin
            lut_words[{ch, tidx}] = tword;
            lut_keys[ch].push_back(tidx);
            table_writes++;
            return;
         end
         if (!enable_reg[ch]) return;
         samples_used++;
         ppl    = clamp_size(ppl_reg, MAX_PIXELS_DEFAULT);
         rows   = clamp_size(rows_reg, MAX_ROWS);
         avg    = clamp_size(avg_reg, MAX_AVG);
         planes = clamp_size(planes_reg, MAX_PLANES_DEFAULT);
         groups = rows / avg;

         // restart any counter left beyond a bound by new settings
         if (pos_x >= ppl) pos_x = 0;
         if (pos_plane >= planes) pos_plane = 0;
         if (pos_line >= avg) pos_line = 0;
         if (pos_row >= rows) begin
            pos_row  = 0;
            pos_line = 0;
         end

         mapped = sample[WORD_W-1] ? 0 : lut_words[{ch, sample[TABLE_INDEX_W-1:0]}];

         // accumulate on whole groups only; emit on the last line of a group
         if (pos_row < groups * avg) begin
            idx = pos_x * MAX_PLANES_DEFAULT + pos_plane;
            if (pos_line == 0) begin
               line_sums[idx]   = SUM_W'(mapped);
               sum_written[idx] = 1'b1;
            end else begin
               line_sums[idx] = line_sums[idx] + SUM_W'(mapped);
            end
            if (pos_line == avg - 1) begin
               row     = pos_row / avg;
               plane_o = pos_plane;
               mean    = (2 * line_sums[idx] + avg) / (2 * avg);
               rank    = 0;
               for (int c = 0; c < ch; c++) rank += enable_reg[c];
               if (scan_reg == SCAN_TWO_WAY && row[0]) plane_o = planes - 1 - pos_plane;
               item.rank          = RANK_W'(rank);
               item.plane_out     = PLANE_OUT_W'(plane_o);
               item.pixel_x       = PIXEL_X_W'(pos_x);
               item.row_out       = ROW_OUT_W'(row);
               item.average_value = WORD_W'(mean);
               item.frame_last    = (pos_x == ppl - 1 && pos_plane == planes - 1 &&
                                     row == groups - 1);
               expected_averages.push_back(item);
            end
         end

         // advance plane, then pixel, then line
         pos_plane++;
         if (pos_plane >= planes) begin
            pos_plane = 0;
            pos_x++;
            if (pos_x >= ppl) begin
               pos_x = 0;
               pos_line++;
               if (pos_line >= avg) pos_line = 0;
               pos_row++;
               if (pos_row >= rows) begin
                  pos_row  = 0;
                  pos_line = 0;
               end
            end
         end
      endfunction

      task check_result(average_item_t got);
         average_item_t want;
         if (expected_averages.size() == 0) begin
            report_mismatch($sformatf("average item with none expected: %p", got));
            return;
         end
         want = expected_averages.pop_front();
         averages_checked++;
         if (got.rank != want.rank)
            report_mismatch($sformatf("channel_rank %0d, expected %0d", got.rank, want.rank));
         if (got.plane_out != want.plane_out)
            report_mismatch($sformatf("plane_out %0d, expected %0d",
                                      got.plane_out, want.plane_out));
         if (got.pixel_x != want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
         if (got.row_out != want.row_out)
            report_mismatch($sformatf("row_out %0d, expected %0d", got.row_out, want.row_out));
         if (got.average_value != want.average_value)
            report_mismatch($sformatf("average_value %h, expected %h",
                                      got.average_value, want.average_value));
         if (got.frame_last != want.frame_last)
            report_mismatch($sformatf("frame_last %0d, expected %0d",
                                      got.frame_last, want.frame_last));
      endtask

      task check_leftovers();
         if (expected_averages.size() != 0)
            report_mismatch($sformatf("%0d averages never arrived", expected_averages.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = MODE_SAMPLE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_AW-1:0]      csr_addr   = '0;
   logic [CSR_DW-1:0]      csr_wdata  = '0;

   line_average_scoreboard sb = new();

   bit          req_burst;
   bit          rsp_burst;
   bit          hold_rsp;
   int unsigned random_items;
   int unsigned settings_used;
   int unsigned quiet_cycles;

   multiplane_line_average_lut dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // -------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("multiplane_line_average_lut_tb: FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   // offer one item after a random gap and hold it until accepted
   task automatic send_item(logic mode, logic [1:0] ch, logic [TABLE_INDEX_W-1:0] tidx,
                            logic [WORD_W-1:0] tword, logic [WORD_W-1:0] sample);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_TDATA_W'({sample, tword, tidx, ch});
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, ch, tidx, tword, sample);
   endtask

   // drop valid and wait until every average is back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [CSR_DW-1:0] ppl, logic [CSR_DW-1:0] rows,
                                 logic [CSR_DW-1:0] avg, logic [CSR_DW-1:0] planes,
                                 logic [CSR_DW-1:0] scan, logic [CSR_DW-1:0] enable);
      csr_index_type     order [6];
      logic [CSR_DW-1:0] values [6];
      order  = '{CSR_PIXELS_PER_LINE, CSR_RAW_ROWS, CSR_LINES_TO_AVERAGE,
                 CSR_PLANE_COUNT, CSR_SCAN_MODE, CSR_CHANNEL_ENABLE};
      values = '{ppl, rows, avg, planes, scan, enable};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= order[i];
         csr_wdata <= values[i];
         @(posedge clock);
         sb.set_reg(order[i], values[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // draw a setting, extremes and out-of-range values included
   task automatic choose_settings();
      logic [CSR_DW-1:0] ppl, rows, avg, planes, enable;
      case ($urandom_range(0, 9))
         0:       ppl = 11'd0;
         1:       ppl = 11'd1;
         2:       ppl = 11'd2047;
         3:       ppl = 11'd1024;
         4:       ppl = 11'd1025;
         default: ppl = CSR_DW'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
         0:       rows = 11'd0;
         1:       rows = 11'd1;
         2:       rows = 11'd2047;
         3:       rows = 11'd1024;
         default: rows = CSR_DW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
         0:       avg = 11'd0;
         1:       avg = 11'd1;
         2:       avg = 11'd16;
         3:       avg = 11'd31;
         default: avg = CSR_DW'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
         0:       planes = 11'd0;
         1:       planes = 11'd1;
         2:       planes = 11'd8;
         3:       planes = 11'd15;
         default: planes = CSR_DW'($urandom_range(1, 4));
      endcase
      enable = CSR_DW'($urandom_range(0, 15));
      if (enable == 0 && $urandom_range(0, 3) != 0) enable = CSR_DW'($urandom_range(1, 15));
      // fall back to single-line groups where a group would read unset sums
      if (!sb.sums_ready(ppl, rows, avg, planes)) avg = 11'd1;
      write_settings(ppl, rows, avg, planes, CSR_DW'($urandom_range(0, 1)), enable);
   endtask

   // mostly samples on enabled channels; some table loads and some noise
   task automatic send_random_item();
      int unsigned pick;
      logic [1:0]  ch;
      logic        mode;
      pick = $urandom_range(0, 99);
      ch   = 2'($urandom);
      mode = (pick < 6) ? MODE_TABLE_WRITE : MODE_SAMPLE;
      if (pick >= 12 && sb.enable_reg != 0) begin
         while (!sb.enable_reg[ch]) ch = 2'($urandom);
      end
      if (mode == MODE_TABLE_WRITE || sb.enable_reg[ch]) random_items++;
      send_item(mode, ch, TABLE_INDEX_W'($urandom), WORD_W'($urandom), sb.pick_sample(ch));
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, one long hold on request
   // -------------------------------------------------------------------------
   initial begin
      int unsigned   stall;
      average_item_t got;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = RSP_HOLD_CYCLES;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.rank          = rsp_tdata[1:0];
         got.plane_out     = rsp_tdata[4:2];
         got.pixel_x       = rsp_tdata[14:5];
         got.row_out       = rsp_tdata[24:15];
         got.average_value = rsp_tdata[40:25];
         got.frame_last    = rsp_tlast;
         sb.check_result(got);
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // one pixel, two planes, pairs of lines, five rows so the last one
      // trails; channel two disabled so ranks skip it
      write_settings(11'd1, 11'd5, 11'd2, 11'd2, CSR_DW'(SCAN_TWO_WAY), 11'b1011);
      send_item(MODE_TABLE_WRITE, 2'd0, 15'h0000, 16'hFFFF, 16'h0000);
      send_item(MODE_TABLE_WRITE, 2'd0, 15'h7FFF, 16'hFFFF, 16'hFFFF);
      send_item(MODE_TABLE_WRITE, 2'd1, 15'h7FFF, 16'h0000, 16'h0000);
      send_item(MODE_TABLE_WRITE, 2'd1, 15'h0000, 16'h0001, 16'h0000);
      // disabled channel still loads its table
      send_item(MODE_TABLE_WRITE, 2'd2, 15'h2AAA, 16'h5555, 16'h0000);
      send_item(MODE_TABLE_WRITE, 2'd3, 15'h5555, 16'hAAAA, 16'h0000);
      // row 0: full-scale sums, rounding at the half, a negative sample
      send_item(MODE_SAMPLE, 2'd0, 15'h0000, 16'h0000, 16'h7FFF);
      send_item(MODE_SAMPLE, 2'd1, 15'h0000, 16'h0000, 16'h0000);
      send_item(MODE_SAMPLE, 2'd2, 15'h0000, 16'h0000, 16'h2AAA);
      send_item(MODE_SAMPLE, 2'd0, 15'h0000, 16'h0000, 16'h0000);
      send_item(MODE_SAMPLE, 2'd3, 15'h0000, 16'h0000, 16'h8000);
      // row 1: odd row reverses the planes, frame end
      send_item(MODE_SAMPLE, 2'd1, 15'h0000, 16'h0000, 16'h7FFF);
      send_item(MODE_SAMPLE, 2'd3, 15'h0000, 16'h0000, 16'h5555);
      send_item(MODE_SAMPLE, 2'd1, 15'h0000, 16'h0000, 16'hFFFF);
      send_item(MODE_SAMPLE, 2'd0, 15'h0000, 16'h0000, 16'h0000);
      // trailing row: no sums, no averages
      send_item(MODE_SAMPLE, 2'd0, 15'h0000, 16'h0000, 16'h7FFF);
      send_item(MODE_SAMPLE, 2'd1, 15'h0000, 16'h0000, 16'h0000);

      // random phases, each under fresh settings written while idle
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         choose_settings();
         if (phase % 8 == 2) hold_rsp = 1'b1;
         req_burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 100)) send_random_item();
         phase++;
      end

      settle();
      sb.check_leftovers();
      $display("covered %0d table loads and %0d accepted samples under %0d settings",
               sb.table_writes, sb.samples_used, settings_used);
      $display("checked %0d averaged items, %0d mismatches", sb.averages_checked, sb.failures);
      if (sb.failures == 0) begin
         $display("multiplane_line_average_lut_tb: PASS");
      end else begin
         $display("multiplane_line_average_lut_tb: FAIL");
      end
      $finish;
   end

endmodule
